/* sv/lgs_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lgs_pkg
// Shared types and constants for the life generation step block: operation
// codes, register indexes, size defaults and the B3/S23 rule counts.
// ----------------------------------------------------------------------------
package lgs_pkg;

  // default storage size of the grid
  localparam int MAX_WIDTH_DEF  = 64;
  localparam int MAX_HEIGHT_DEF = 64;

  // operation codes carried in tuser
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_STEP  = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  // configuration registers
  localparam int         CFG_DATA_W      = 7;
  localparam logic       REG_GRID_WIDTH  = 1'b0;
  localparam logic       REG_GRID_HEIGHT = 1'b1;
  localparam logic [6:0] GRID_SIZE_RESET = 7'd64;

  // rule counts on the eight-neighbor sum
  localparam logic [3:0] BIRTH_COUNT   = 4'd3;
  localparam logic [3:0] SURVIVE_COUNT = 4'd2;

  // per-column vertical sum handed between neighbor cells
  typedef logic [1:0] col_sum_t;

endpackage

/* sv/lgs_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lgs_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module lgs_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sv/lgs_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lgs_cell
// One column of the generation window: holds the up, current and down bits
// of its column and computes the next state from its neighbors' sums.
// ----------------------------------------------------------------------------
module lgs_cell (
  input  logic                clk,
  input  logic                shift,
  input  logic                din,
  input  logic                in_use,
  input  lgs_pkg::col_sum_t   left_sum,
  input  lgs_pkg::col_sum_t   right_sum,
  output lgs_pkg::col_sum_t   col_sum,
  output logic                next_bit
);
  import lgs_pkg::*;

  logic up;
  logic cur;
  logic dn;
  logic [3:0] total;
  logic [3:0] nbr;
  logic       live;

  // three-row window, a new row enters at the bottom
  always_ff @(posedge clk) begin
    if (shift) begin
      up  <= cur;
      cur <= dn;
      dn  <= din;
    end
  end

  // vertical sum of this column, handed to both neighbors
  assign col_sum = col_sum_t'({1'b0, up} + {1'b0, cur} + {1'b0, dn});

  // eight-neighbor count and B3/S23 rule
  assign total = 4'(left_sum) + 4'(col_sum) + 4'(right_sum);
  assign nbr   = total - 4'(cur);
  assign live  = (nbr == BIRTH_COUNT) || (cur && (nbr == SURVIVE_COUNT));

  // columns outside the area keep their value
  assign next_bit = in_use ? live : cur;

endmodule

/* sv/lgs_cell_row.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lgs_cell_row
// Row of column cells with toroidal wrap at the active width. Produces the
// next generation of the row in the middle of the window.
// ----------------------------------------------------------------------------
module lgs_cell_row #(
  parameter int MAX_WIDTH = 64,
  localparam int WW = $clog2(MAX_WIDTH + 1),
  localparam int CW = $clog2(MAX_WIDTH)
) (
  input  logic                 clk,
  input  logic                 shift,
  input  logic [MAX_WIDTH-1:0] shift_row,
  input  logic [WW-1:0]        width_eff,
  output logic [MAX_WIDTH-1:0] next_row
);
  import lgs_pkg::*;

  col_sum_t           sums [MAX_WIDTH];
  logic [MAX_WIDTH-1:0] in_use;
  logic [MAX_WIDTH-1:0] last_col;
  logic [CW-1:0]      last_idx;
  col_sum_t           wrap_sum;

  // column at the right edge feeds the left side of column zero
  assign last_idx = CW'(width_eff - WW'(1));
  assign wrap_sum = sums[last_idx];

  for (genvar i = 0; i < MAX_WIDTH; i++) begin : g_col
    col_sum_t left_sum;
    col_sum_t right_sum;

    assign in_use[i]   = width_eff > WW'(i);
    assign last_col[i] = width_eff == WW'(i + 1);

    // wrap neighbors at the active width
    if (i == 0) begin : g_first
      assign left_sum = wrap_sum;
    end else begin : g_mid
      assign left_sum = sums[i-1];
    end
    if (i == MAX_WIDTH - 1) begin : g_last
      assign right_sum = sums[0];
    end else begin : g_inner
      assign right_sum = last_col[i] ? sums[0] : sums[i+1];
    end

    lgs_cell u_col (
      .clk       (clk),
      .shift     (shift),
      .din       (shift_row[i]),
      .in_use    (in_use[i]),
      .left_sum  (left_sum),
      .right_sum (right_sum),
      .col_sum   (sums[i]),
      .next_bit  (next_row[i])
    );
  end

endmodule

/* sv/life_generation_step_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// life_generation_step_top
// Toroidal B3/S23 grid: write a cell, read a cell or advance one generation.
// ----------------------------------------------------------------------------
// Usage
//   Requests arrive on the s_ stream: tuser carries the operation (write,
//   step, read), tdata the column, row and value. Each request gives exactly
//   one result on the m_ stream: the cell value of a read in tdata (zero
//   otherwise) and the echoed operation in tuser.
//   Cell write and read do one RAM read, then modify-write or bit select.
//   A generation step reads the row RAM once per row plus the wrapped top
//   row, passes the rows through a three-row window in the cell row, and
//   writes each new row back one per cycle, the last one once the result
//   register is free. One request is in work at a time; the next is taken
//   the cycle after the previous result is registered.
//   The result register holds while the receiver stalls; a new request is
//   still accepted, and its completion waits until the register is free.
//   After reset the grid RAM is cleared; no request is accepted during the
//   clearing pass. Configuration writes are taken at any time and both sizes
//   reset to 64.
// ----------------------------------------------------------------------------
module life_generation_step_top #(
  parameter int MAX_WIDTH  = lgs_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = lgs_pkg::MAX_HEIGHT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [lgs_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // col [5:0], row [11:6], alive [12], zero [15:13]
  input  logic [1:0]  s_tuser,   // func [1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // cell_out [0], zero [7:1]
  output logic [1:0]  m_tuser    // done_op [1:0]
);
  import lgs_pkg::*;

  localparam int WW   = $clog2(MAX_WIDTH + 1);
  localparam int HW   = $clog2(MAX_HEIGHT + 1);
  localparam int AW   = $clog2(MAX_HEIGHT);
  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int CNTW = $clog2(MAX_HEIGHT + 4);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_CELL  = 2'd2;
  localparam logic [1:0] ST_STEP  = 2'd3;

  logic [1:0]      state;
  logic [CNTW-1:0] cnt;
  logic [6:0]      grid_width;
  logic [6:0]      grid_height;
  logic [1:0]      op_func;
  logic [5:0]      op_col;
  logic [5:0]      op_row;
  logic            op_alive;
  logic [MAX_WIDTH-1:0] row0_save;
  logic            out_cell;
  logic [1:0]      out_op;

  logic [WW-1:0]   eff_w;
  logic [HW-1:0]   eff_h;
  logic [CNTW-1:0] step_end;
  logic            in_area;
  logic            out_free;
  logic            last;
  logic            adv;
  logic            shift;
  logic [MAX_WIDTH-1:0] shift_row;
  logic [MAX_WIDTH-1:0] next_row;
  logic [CW-1:0]   bit_idx;

  logic                 we;
  logic [AW-1:0]        waddr;
  logic [MAX_WIDTH-1:0] wdata;
  logic [AW-1:0]        raddr;
  logic [MAX_WIDTH-1:0] rdata;

  // active size, held within 1..max
  always_comb begin
    if (grid_width == 7'd0) begin
      eff_w = WW'(1);
    end else if (32'(grid_width) > MAX_WIDTH) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(grid_width);
    end
    if (grid_height == 7'd0) begin
      eff_h = HW'(1);
    end else if (32'(grid_height) > MAX_HEIGHT) begin
      eff_h = HW'(MAX_HEIGHT);
    end else begin
      eff_h = HW'(grid_height);
    end
  end

  // handshake and sequencing conditions
  assign step_end = CNTW'(eff_h) + CNTW'(3);
  assign in_area  = (32'(op_col) < 32'(eff_w)) && (32'(op_row) < 32'(eff_h));
  assign bit_idx  = CW'(op_col);
  assign out_free = !m_tvalid || m_tready;
  assign last     = ((state == ST_CELL) && (cnt == CNTW'(1))) ||
                    ((state == ST_STEP) && (cnt == step_end));
  assign adv      = !last || out_free;
  assign s_tready = (state == ST_IDLE);

  // window feed: wrapped top row first, saved row zero last
  assign shift     = (state == ST_STEP) && adv;
  assign shift_row = (cnt == step_end - CNTW'(1)) ? row0_save : rdata;

  // RAM read address
  always_comb begin
    case (state)
      ST_CELL: raddr = AW'(op_row);
      ST_STEP: begin
        if (cnt == '0) begin
          raddr = AW'(eff_h - HW'(1));
        end else begin
          raddr = AW'(cnt - CNTW'(1));
        end
      end
      default: raddr = '0;
    endcase
  end

  // RAM write: clearing pass, cell update, or new generation row
  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = rdata;
    case (state)
      ST_CLEAR: begin
        we    = 1'b1;
        waddr = AW'(cnt);
        wdata = '0;
      end
      ST_CELL: begin
        we    = (cnt == CNTW'(1)) && (op_func == OP_WRITE) && in_area && adv;
        waddr = AW'(op_row);
        wdata[bit_idx] = op_alive;
      end
      ST_STEP: begin
        we    = (cnt >= CNTW'(4)) && adv;
        waddr = AW'(cnt - CNTW'(4));
        wdata = next_row;
      end
      default: we = 1'b0;
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= GRID_SIZE_RESET;
      grid_height <= GRID_SIZE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GRID_WIDTH:  grid_width  <= cfg_data;
        REG_GRID_HEIGHT: grid_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // control sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      cnt   <= '0;
    end else begin
      case (state)
        ST_CLEAR: begin
          if (cnt == CNTW'(MAX_HEIGHT - 1)) begin
            state <= ST_IDLE;
            cnt   <= '0;
          end else begin
            cnt <= cnt + CNTW'(1);
          end
        end
        ST_IDLE: begin
          if (s_tvalid) begin
            state <= (s_tuser == OP_STEP) ? ST_STEP : ST_CELL;
            cnt   <= '0;
          end
        end
        ST_CELL, ST_STEP: begin
          if (last && adv) begin
            state <= ST_IDLE;
            cnt   <= '0;
          end else if (adv) begin
            cnt <= cnt + CNTW'(1);
          end
        end
        default: begin
          state <= ST_IDLE;
          cnt   <= '0;
        end
      endcase
    end
  end

  // request capture and saved row zero
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      op_func  <= s_tuser;
      op_col   <= s_tdata[5:0];
      op_row   <= s_tdata[11:6];
      op_alive <= s_tdata[12];
    end
    if ((state == ST_STEP) && (cnt == CNTW'(2))) begin
      row0_save <= rdata;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (last && adv) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (last && adv) begin
      out_op   <= op_func;
      out_cell <= (state == ST_CELL) && (op_func == OP_READ) && in_area && rdata[bit_idx];
    end
  end

  assign m_tdata = {7'd0, out_cell};
  assign m_tuser = out_op;

  lgs_ram #(
    .WIDTH (MAX_WIDTH),
    .DEPTH (MAX_HEIGHT)
  ) u_grid_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  lgs_cell_row #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_cell_row (
    .clk       (clk),
    .shift     (shift),
    .shift_row (shift_row),
    .width_eff (eff_w),
    .next_row  (next_row)
  );

  // no request taken while the grid is being cleared
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |-> !s_tready)
    else $error("request accepted during clearing pass");

  // an accepted request starts work in the next cycle
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> ((state == ST_CELL) || (state == ST_STEP)))
    else $error("accepted request did not start");

  // generation writes stay inside the active height
  a_step_write_area: assert property (@(posedge clk) disable iff (rst)
    (we && (state == ST_STEP)) |-> (32'(waddr) < 32'(eff_h)))
    else $error("generation write outside active rows");

  // the RAM is written only while work is in progress
  a_write_busy: assert property (@(posedge clk) disable iff (rst)
    we |-> (state != ST_IDLE))
    else $error("grid written while idle");

endmodule
